// ----- rtl/core/sema_pkg.sv -----
// shared constants and the exp2 table for the superellipse mask pipeline
package sema_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_SIZE   = 256;
  localparam int MIN_SIZE   = 4;
  localparam int EXP_Q      = 30;
  localparam int NUM_W      = 25;   // dividend width: 9-bit magnitude above FRAC_BITS
  localparam int DIV_STAGES = 5;
  localparam int DIV_BITS   = NUM_W / DIV_STAGES;
  localparam int LOG_STEPS  = FRAC_BITS;
  localparam int EXP_STEPS  = FRAC_BITS;
  // lane stages: operand, divider, normalize, squarings, product, split, exp, shift
  localparam int LANE_LAT   = 1 + DIV_STAGES + 1 + LOG_STEPS + 1 + 1 + EXP_STEPS + 1;

  localparam logic [3:0] REG_MASK_SIZE = 4'd0;
  localparam logic [3:0] REG_SHAPE_EXP = 4'd1;

  // 2^(2^-(i+1)) in Q1.30
  function automatic logic [30:0] exp2_tab(input int i);
    logic [30:0] v;
    case (i)
      0:       v = 31'd1518500250;
      1:       v = 31'd1276901417;
      2:       v = 31'd1170923762;
      3:       v = 31'd1121280436;
      4:       v = 31'd1097253708;
      5:       v = 31'd1085434106;
      6:       v = 31'd1079572136;
      7:       v = 31'd1076653033;
      8:       v = 31'd1075196444;
      9:       v = 31'd1074468887;
      10:      v = 31'd1074105294;
      11:      v = 31'd1073923544;
      12:      v = 31'd1073832680;
      13:      v = 31'd1073787251;
      14:      v = 31'd1073764537;
      15:      v = 31'd1073753181;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/sema_lane.sv -----
// one coordinate lane: normalize by division, log2 by squaring, exp2 by table products
module sema_lane (
  input  logic        clk,
  input  logic        adv,
  input  logic [7:0]  coord,
  input  logic [8:0]  size,
  input  logic [7:0]  den,
  input  logic [11:0] expo,
  output logic [17:0] pwr
);

  localparam int DS = sema_pkg::DIV_STAGES;
  localparam int LS = sema_pkg::LOG_STEPS;
  localparam int ES = sema_pkg::EXP_STEPS;
  localparam int NW = sema_pkg::NUM_W;

  // operand stage
  logic [10:0]   off;
  logic [8:0]    mag;
  logic [7:0]    rem_r [DS+1];
  logic [NW-1:0] nq_r  [DS+1];

  always_comb begin
    off = {2'b00, coord, 1'b0} + 11'd1 - {2'b00, size};
    mag = off[10] ? 9'(-off) : off[8:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= 8'd0;
      nq_r[0]  <= NW'({mag, 16'd0}) + NW'(den >> 1);
    end
  end

  // restoring divider, quotient bits shift in at the bottom
  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [7:0]    rem_nxt;
    logic [NW-1:0] nq_nxt;
    logic [8:0]    t9;
    always_comb begin
      rem_nxt = rem_r[s];
      nq_nxt  = nq_r[s];
      t9      = 9'd0;
      for (int j = 0; j < sema_pkg::DIV_BITS; j++) begin
        t9     = {rem_nxt, nq_nxt[NW-1]};
        nq_nxt = {nq_nxt[NW-2:0], 1'b0};
        if (t9 >= {1'b0, den}) begin
          rem_nxt   = 8'(t9 - {1'b0, den});
          nq_nxt[0] = 1'b1;
        end else begin
          rem_nxt = t9[7:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s+1] <= rem_nxt;
        nq_r[s+1]  <= nq_nxt;
      end
    end
  end

  // saturate, find leading one, normalize mantissa
  logic [17:0] v;
  logic [4:0]  e;
  logic [33:0] vsh;
  logic [16:0] m_r  [LS+1];
  logic [15:0] fr_r [LS+1];
  logic [4:0]  e_r  [LS+1];
  logic        z_r  [LS+1];

  always_comb begin
    v = (nq_r[DS] > NW'(18'h3FFFF)) ? 18'h3FFFF : nq_r[DS][17:0];
    e = 5'd0;
    for (int b = 0; b < 18; b++) begin
      if (v[b]) e = 5'(b);
    end
    vsh = {v, 16'd0} >> e;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0]  <= vsh[16:0];
      fr_r[0] <= 16'd0;
      e_r[0]  <= e;
      z_r[0]  <= (v == 18'd0);
    end
  end

  // one squaring per stage gives one fraction bit
  for (genvar i = 0; i < LS; i++) begin : g_log
    logic [33:0] sq;
    logic [17:0] sqh;
    always_comb begin
      sq  = {17'd0, m_r[i]} * {17'd0, m_r[i]};
      sqh = sq[33:16];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[i+1]  <= sqh[17] ? sqh[17:1] : sqh[16:0];
        fr_r[i+1] <= {fr_r[i][14:0], sqh[17]};
        e_r[i+1]  <= e_r[i];
        z_r[i+1]  <= z_r[i];
      end
    end
  end

  // log2 times exponent
  logic signed [21:0] lg;
  logic signed [34:0] p_r;
  logic               pz_r;
  logic [5:0]         eu;

  always_comb begin
    eu = {1'b0, e_r[LS]} - 6'd16;
    lg = $signed({eu, fr_r[LS]});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= 35'(lg * $signed({1'b0, expo}));
      pz_r <= z_r[LS];
    end
  end

  // split into integer part and fraction
  logic signed [10:0] k;
  logic [10:0]        shf;
  logic [30:0]        acc_r  [ES+1];
  logic [15:0]        f_r    [ES+1];
  logic [4:0]         sh_r   [ES+1];
  logic               zv_r   [ES+1];
  logic               sat_r  [ES+1];
  logic               tiny_r [ES+1];

  always_comb begin
    k   = p_r[34:24];
    shf = 11'd14 - k;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r[0]  <= 31'(1) << sema_pkg::EXP_Q;
      f_r[0]    <= p_r[23:8];
      sh_r[0]   <= shf[4:0];
      zv_r[0]   <= pz_r;
      sat_r[0]  <= !k[10] && (k != 11'sd0);
      tiny_r[0] <= k < -11'sd16;
    end
  end

  // one table product per stage, fraction bits msb first
  for (genvar i = 0; i < ES; i++) begin : g_exp
    logic [61:0] prod;
    always_comb prod = {31'd0, acc_r[i]} * {31'd0, sema_pkg::exp2_tab(i)};
    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r[i+1]  <= f_r[i][ES-1-i] ? prod[60:30] : acc_r[i];
        f_r[i+1]    <= f_r[i];
        sh_r[i+1]   <= sh_r[i];
        zv_r[i+1]   <= zv_r[i];
        sat_r[i+1]  <= sat_r[i];
        tiny_r[i+1] <= tiny_r[i];
      end
    end
  end

  // final shift to Q2.16
  logic [17:0] pwr_r;
  logic [30:0] accs;

  always_comb accs = acc_r[ES] >> sh_r[ES];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zv_r[ES] || tiny_r[ES]) begin
        pwr_r <= 18'd0;
      end else if (sat_r[ES]) begin
        pwr_r <= 18'(1) << (sema_pkg::FRAC_BITS + 1);
      end else begin
        pwr_r <= accs[17:0];
      end
    end
  end

  assign pwr = pwr_r;

endmodule

// ----- rtl/core/superellipse_mask_alpha_top.sv -----
// superellipse mask alpha: an in beat runs through both lanes, then the t and alpha registers, to the out beat
// throughput one pixel per clock; the whole pipeline holds while out is stalled
// the two lanes (divide, 16 squarings, 16 table products) set the depth
// rst_n (synchronous) clears the valid bits and sets mask_size 256, shape_exponent 4.0
// cfg_ready is always high, a write takes effect at once
module superellipse_mask_alpha_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pixel_x [7:0], pixel_y [15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // alpha [7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int LAT = sema_pkg::LANE_LAT;

  // configuration registers
  logic [8:0]  mask_size_r;
  logic [11:0] shape_exp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_size_r <= 9'd256;
      shape_exp_r <= 12'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        sema_pkg::REG_MASK_SIZE: mask_size_r <= cfg_data[8:0];
        sema_pkg::REG_SHAPE_EXP: shape_exp_r <= cfg_data;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // clamped size and radius denominator size-2
  logic [8:0] size_c;
  logic [7:0] den;
  logic [8:0] den9;

  always_comb begin
    if (mask_size_r < 9'(sema_pkg::MIN_SIZE)) begin
      size_c = 9'(sema_pkg::MIN_SIZE);
    end else if (mask_size_r > 9'(sema_pkg::MAX_SIZE)) begin
      size_c = 9'(sema_pkg::MAX_SIZE);
    end else begin
      size_c = mask_size_r;
    end
    den9 = size_c - 9'd2;
    den  = den9[7:0];
  end

  // single pipeline enable: advance unless the output beat is held
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // valid bits follow the lane stages
  logic [LAT-1:0] vld_r;
  logic           t_vld_r;
  logic           out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      t_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[LAT-2:0], in_tvalid};
      t_vld_r   <= vld_r[LAT-1];
      out_vld_r <= t_vld_r;
    end
  end

  // per-coordinate power lanes
  logic [17:0] pwr_x;
  logic [17:0] pwr_y;

  sema_lane u_lane_x (
    .clk   (clk),
    .adv   (adv),
    .coord (in_tdata[7:0]),
    .size  (size_c),
    .den   (den),
    .expo  (shape_exp_r),
    .pwr   (pwr_x)
  );

  sema_lane u_lane_y (
    .clk   (clk),
    .adv   (adv),
    .coord (in_tdata[15:8]),
    .size  (size_c),
    .den   (den),
    .expo  (shape_exp_r),
    .pwr   (pwr_y)
  );

  // distance scaled by radius: t = (px + py - 1.0) * (size - 2)
  logic signed [19:0] dsum;
  logic signed [27:0] t_r;

  always_comb dsum = $signed({1'b0, ({1'b0, pwr_x} + {1'b0, pwr_y})}) - 20'sd65536;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r <= 28'(dsum * $signed({1'b0, den}));
    end
  end

  // ramp: round(255 * (t + 1) / 2) in Q.16, clipped at both ends
  logic [16:0] tp;
  logic [26:0] ramp;
  logic [7:0]  alpha_r;

  always_comb begin
    tp   = 17'(t_r + 28'sd65536);
    ramp = ({10'd0, tp} << 8) - {10'd0, tp} + 27'd65536;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (t_r <= -28'sd65536) begin
        alpha_r <= 8'd0;
      end else if (t_r >= 28'sd65536) begin
        alpha_r <= 8'd255;
      end else begin
        alpha_r <= ramp[24:17];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = alpha_r;

endmodule
